@@ sv/bap_pkg.sv @@
// Shared request and status codes for the buddy page allocator.
// No dependencies.
package bap_pkg;

    localparam int ORDER_W = 4;

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;
    typedef logic [ORDER_W-1:0] order_t;

    localparam req_t REQ_INIT  = 2'd0;
    localparam req_t REQ_ALLOC = 2'd1;
    localparam req_t REQ_FREE  = 2'd2;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_FAIL    = 2'd1;
    localparam status_t ST_IGNORED = 2'd2;
    localparam status_t ST_INIT    = 2'd3;

    localparam int CFG_BASE  = 0;
    localparam int CFG_COUNT = 1;

endpackage

@@ sv/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: request sequencer and list heads.
// Depends on bap_pkg and bap_page_ram.
//
// Usage: pulse start with a request while busy is low. The block answers
// with exactly one word: done is high for one cycle with status,
// page_index and phys_address valid; there is no way to stall it, so
// sample it on that cycle. busy stays high from the accepting edge until
// the result word appears. After reset the block sweeps its page store
// clean with busy high. An init request does the same sweep and then
// pushes each whole top-order block. An allocate that finds no block
// goes straight to its result word. An allocate that succeeds unlinks
// the head block of the lowest fitting list, then each split pushes the
// upper half onto the list one order down, then the block is marked
// allocated. A refused superpage goes on with the merge and push of a
// free. A free that is ignored ends without touching any list. An
// accepted free clears the allocated flag, unlinks each free buddy it
// merges with, then pushes the merged block. The pace is set by the
// single page store: each metadata update is a registered read, then a
// write. Configuration words may be written at any time; base_address and
// page_count are read live by every request.
module buddy_page_allocator #(
    parameter int PAGE_DEPTH = 4096,
    parameter int TOP_ORDER  = 10,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bap_pkg::req_t        req_type,
    input  logic [3:0]           block_order,
    input  logic                 want_superpage,
    input  logic [11:0]          free_index,
    output logic                 done,
    output bap_pkg::status_t     status,
    output logic [11:0]          page_index,
    output logic [31:0]          phys_address,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import bap_pkg::*;

    localparam int IDX_W   = $clog2(PAGE_DEPTH);
    localparam int LW      = IDX_W + 1;
    localparam int EW      = 2 * LW + ORDER_W + 2;
    localparam int PB_SH   = $clog2(PAGE_BYTES);
    localparam int ALIGN_W = PB_SH + TOP_ORDER;
    localparam logic [31:0] ALIGN_MASK = (ALIGN_W >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << ALIGN_W) - 64'd1);
    localparam logic [31:0] SZ = 32'd1 << TOP_ORDER;
    localparam logic [LW-1:0] NIL = LW'(PAGE_DEPTH);
    localparam order_t TOP = ORDER_W'(TOP_ORDER);

    // entry layout: {next, prev, order, allocated, free_head}
    localparam int NX_LO = LW + ORDER_W + 2;
    localparam int PV_LO = ORDER_W + 2;
    localparam int OR_LO = 2;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLEAR    = 5'd1;
    localparam logic [4:0] S_PUSH_W   = 5'd2;
    localparam logic [4:0] S_PUSH_R   = 5'd3;
    localparam logic [4:0] S_PUSH_M   = 5'd4;
    localparam logic [4:0] S_PUSH_END = 5'd5;
    localparam logic [4:0] S_UNL_A    = 5'd6;
    localparam logic [4:0] S_UNL_PR   = 5'd7;
    localparam logic [4:0] S_UNL_PW   = 5'd8;
    localparam logic [4:0] S_UNL_NR   = 5'd9;
    localparam logic [4:0] S_UNL_NW   = 5'd10;
    localparam logic [4:0] S_UNL_END  = 5'd11;
    localparam logic [4:0] S_SPLIT    = 5'd12;
    localparam logic [4:0] S_ALC_RD   = 5'd13;
    localparam logic [4:0] S_ALC_W    = 5'd14;
    localparam logic [4:0] S_MRG      = 5'd15;
    localparam logic [4:0] S_MRG_CK   = 5'd16;
    localparam logic [4:0] S_FRE_CK   = 5'd17;
    localparam logic [4:0] S_FIN      = 5'd18;

    logic [4:0]       state_reg, state_next;
    req_t             op_reg, op_next;
    logic             rel_reg, rel_next;
    logic             fail_reg, fail_next;
    logic             sup_reg, sup_next;
    order_t           ord_reg, ord_next;
    order_t           cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pa_reg, pa_next;
    logic [IDX_W-1:0] ua_reg, ua_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [LW-1:0]    h_reg, h_next;
    logic [LW-1:0]    p_reg, p_next;
    logic [LW-1:0]    n_reg, n_next;
    logic [LW-1:0]    head_reg [TOP_ORDER+1];
    logic [LW-1:0]    head_next [TOP_ORDER+1];
    logic             done_reg, done_next;
    status_t          st_reg, st_next;
    logic [11:0]      pi_reg, pi_next;
    logic [31:0]      phys_reg, phys_next;
    logic [31:0]      base_reg;
    logic [12:0]      count_reg;

    logic             mem_re, mem_we;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    logic [EW-1:0]    mem_wdata, mem_rdata;

    logic [LW-1:0]    rd_next_f, rd_prev_f;
    order_t           rd_order_f;
    logic             rd_alloc_f, rd_fhm_f;
    logic [31:0]      np32;
    logic [31:0]      idx_phys;
    logic [31:0]      init_nx;
    logic [IDX_W-1:0] bud;
    logic             found;
    order_t           found_ord;

    bap_page_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (EW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    assign rd_next_f  = mem_rdata[NX_LO +: LW];
    assign rd_prev_f  = mem_rdata[PV_LO +: LW];
    assign rd_order_f = mem_rdata[OR_LO +: ORDER_W];
    assign rd_alloc_f = mem_rdata[1];
    assign rd_fhm_f   = mem_rdata[0];

    // Clamp page_count to the store depth.
    assign np32 = (32'(count_reg) > 32'(PAGE_DEPTH)) ? 32'(PAGE_DEPTH) : 32'(count_reg);
    assign idx_phys = base_reg + (32'(idx_reg) << PB_SH);
    assign init_nx  = 32'(idx_reg) + SZ;
    assign bud      = idx_reg ^ (IDX_W'(1) << cur_reg);

    // Lowest non-empty list at or above the requested order.
    always_comb
    begin
        found     = 1'b0;
        found_ord = '0;
        for (int i = TOP_ORDER; i >= 0; i--)
        begin
            if (head_reg[i] != NIL && ORDER_W'(i) >= block_order)
            begin
                found     = 1'b1;
                found_ord = ORDER_W'(i);
            end
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'(CFG_BASE))
            begin
                base_reg <= cfg_data;
            end
            else
            begin
                count_reg <= cfg_data[12:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        rel_next   = rel_reg;
        fail_next  = fail_reg;
        sup_next   = sup_reg;
        ord_next   = ord_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        pa_next    = pa_reg;
        ua_next    = ua_reg;
        clr_next   = clr_reg;
        h_next     = h_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        head_next  = head_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        pi_next    = pi_reg;
        phys_next  = phys_reg;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req_type;
                    ord_next  = block_order;
                    sup_next  = want_superpage;
                    rel_next  = 1'b0;
                    fail_next = 1'b0;
                    st_next   = ST_IGNORED;
                    pi_next   = '0;
                    phys_next = '0;
                    state_next = S_FIN;
                    case (req_type)
                        REQ_INIT:
                        begin
                            for (int i = 0; i <= TOP_ORDER; i++)
                            begin
                                head_next[i] = NIL;
                            end
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        REQ_ALLOC:
                        begin
                            st_next = ST_FAIL;
                            if (block_order <= TOP && found)
                            begin
                                cur_next   = found_ord;
                                idx_next   = head_reg[found_ord][IDX_W-1:0];
                                ua_next    = head_reg[found_ord][IDX_W-1:0];
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg[found_ord][IDX_W-1:0];
                                state_next = S_UNL_A;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (block_order <= TOP && 32'(free_index) < np32 &&
                                32'(free_index) + (32'd1 << block_order) <= np32)
                            begin
                                idx_next   = IDX_W'(free_index);
                                mem_re     = 1'b1;
                                mem_raddr  = IDX_W'(free_index);
                                state_next = S_FRE_CK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(PAGE_DEPTH - 1))
                begin
                    if (op_reg == REQ_INIT)
                    begin
                        idx_next = '0;
                        pa_next  = '0;
                        cur_next = TOP;
                        st_next  = ST_INIT;
                        state_next = (SZ <= np32) ? S_PUSH_W : S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // push pa_reg on list cur_reg
            S_PUSH_W:
            begin
                h_next    = head_reg[cur_reg];
                mem_we    = 1'b1;
                mem_waddr = pa_reg;
                mem_wdata = {head_reg[cur_reg], NIL, cur_reg, 1'b0, 1'b1};
                head_next[cur_reg] = {1'b0, pa_reg};
                state_next = (head_reg[cur_reg] != NIL) ? S_PUSH_R : S_PUSH_END;
            end

            S_PUSH_R:
            begin
                mem_re     = 1'b1;
                mem_raddr  = h_reg[IDX_W-1:0];
                state_next = S_PUSH_M;
            end

            S_PUSH_M:
            begin
                mem_we    = 1'b1;
                mem_waddr = h_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                mem_wdata[PV_LO +: LW] = {1'b0, pa_reg};
                state_next = S_PUSH_END;
            end

            S_PUSH_END:
            begin
                if (op_reg == REQ_INIT)
                begin
                    if (init_nx + SZ <= np32)
                    begin
                        idx_next   = IDX_W'(init_nx);
                        pa_next    = IDX_W'(init_nx);
                        state_next = S_PUSH_W;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (rel_reg)
                begin
                    st_next    = fail_reg ? ST_FAIL : ST_DONE;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end

            // unlink ua_reg from list cur_reg; its entry sits in the read data
            S_UNL_A:
            begin
                p_next    = rd_prev_f;
                n_next    = rd_next_f;
                mem_we    = 1'b1;
                mem_waddr = ua_reg;
                mem_wdata = mem_rdata;
                mem_wdata[0] = 1'b0;
                if (rd_prev_f == NIL)
                begin
                    head_next[cur_reg] = rd_next_f;
                end
                if (rd_prev_f != NIL)
                begin
                    state_next = S_UNL_PR;
                end
                else if (rd_next_f != NIL)
                begin
                    state_next = S_UNL_NR;
                end
                else
                begin
                    state_next = S_UNL_END;
                end
            end

            S_UNL_PR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = p_reg[IDX_W-1:0];
                state_next = S_UNL_PW;
            end

            S_UNL_PW:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                mem_wdata[NX_LO +: LW] = n_reg;
                state_next = (n_reg != NIL) ? S_UNL_NR : S_UNL_END;
            end

            S_UNL_NR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = n_reg[IDX_W-1:0];
                state_next = S_UNL_NW;
            end

            S_UNL_NW:
            begin
                mem_we    = 1'b1;
                mem_waddr = n_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                mem_wdata[PV_LO +: LW] = p_reg;
                state_next = S_UNL_END;
            end

            S_UNL_END:
            begin
                if (rel_reg)
                begin
                    idx_next   = idx_reg & ~(IDX_W'(1) << cur_reg);
                    cur_next   = cur_reg + 1'b1;
                    state_next = S_MRG;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end

            // push upper halves until the block has the requested order
            S_SPLIT:
            begin
                if (cur_reg > ord_reg)
                begin
                    cur_next   = cur_reg - 1'b1;
                    pa_next    = idx_reg + (IDX_W'(1) << (cur_reg - 1'b1));
                    state_next = S_PUSH_W;
                end
                else
                begin
                    state_next = S_ALC_RD;
                end
            end

            S_ALC_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_ALC_W;
            end

            S_ALC_W:
            begin
                fail_next = sup_reg && (ord_reg != TOP || (idx_phys & ALIGN_MASK) != '0);
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_wdata[OR_LO +: ORDER_W] = ord_reg;
                mem_wdata[1] = !fail_next;
                if (fail_next)
                begin
                    rel_next   = 1'b1;
                    cur_next   = ord_reg;
                    state_next = S_MRG;
                end
                else
                begin
                    st_next    = ST_DONE;
                    pi_next    = 12'(idx_reg);
                    phys_next  = idx_phys;
                    state_next = S_FIN;
                end
            end

            // try to merge idx_reg at order cur_reg with its buddy
            S_MRG:
            begin
                if (cur_reg < TOP && {1'b0, bud} < LW'(np32))
                begin
                    ua_next    = bud;
                    mem_re     = 1'b1;
                    mem_raddr  = bud;
                    state_next = S_MRG_CK;
                end
                else
                begin
                    pa_next    = idx_reg;
                    state_next = S_PUSH_W;
                end
            end

            S_MRG_CK:
            begin
                if (rd_fhm_f && !rd_alloc_f && rd_order_f == cur_reg)
                begin
                    state_next = S_UNL_A;
                end
                else
                begin
                    pa_next    = idx_reg;
                    state_next = S_PUSH_W;
                end
            end

            S_FRE_CK:
            begin
                if (rd_alloc_f)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = mem_rdata;
                    mem_wdata[1] = 1'b0;
                    rel_next   = 1'b1;
                    cur_next   = ord_reg;
                    state_next = S_MRG;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg    <= REQ_FREE;
            rel_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                head_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            rel_reg   <= rel_next;
            fail_reg  <= fail_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sup_reg  <= sup_next;
        ord_reg  <= ord_next;
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        pa_reg   <= pa_next;
        ua_reg   <= ua_next;
        h_reg    <= h_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        st_reg   <= st_next;
        pi_reg   <= pi_next;
        phys_reg <= phys_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = st_reg;
    assign page_index   = pi_reg;
    assign phys_address = phys_reg;

endmodule

@@ sv/bap_page_ram.sv @@
// Per-page metadata store: one write port, one read port, registered read.
// No dependencies.
module bap_page_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [1<<ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bap_checker.sv @@
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bap_pkg.
module bap_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bap_pkg::status_t status,
    input logic [11:0]      page_index,
    input logic [31:0]      phys_address
);
    import bap_pkg::*;

    // an accepted request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_DONE |-> page_index == '0 && phys_address == '0)
        else $error("nonzero address on a non-allocation result");

endmodule

bind buddy_page_allocator bap_checker u_bap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .page_index   (page_index),
    .phys_address (phys_address)
);

@@ bench/tb_buddy_page_allocator.sv @@
`timescale 1ns / 100ps
// Self-checking bench for buddy_page_allocator: random and directed requests
// against a behavioral free-list model held in a small scoreboard class.
// Depends on bap_pkg and the allocator RTL.
module tb_buddy_page_allocator;
    import bap_pkg::*;

    localparam int NPAGES   = 4096;
    localparam int TOPO     = 10;
    localparam int NIL      = NPAGES;
    localparam int LIMIT    = 3000000;
    localparam int SETTLE   = 100;

    typedef struct {
        status_t     st;
        logic [11:0] idx;
        logic [31:0] addr;
    } answer_t;

    typedef struct {
        int idx;
        int ord;
    } block_t;

    // Free-list model of the allocator plus the queue of pending answers.
    class alloc_scoreboard;
        logic [31:0] base_addr;
        int          count_reg;
        int          nxt[NPAGES];
        int          prv[NPAGES];
        int          ord_of[NPAGES];
        bit          taken[NPAGES];
        bit          on_list[NPAGES];
        int          head[TOPO+1];
        answer_t     pending[$];
        int          errors;
        int          checked;

        function new();
            base_addr = 0;
            count_reg = 4096;
            errors    = 0;
            checked   = 0;
            for (int i = 0; i < NPAGES; i++)
            begin
                nxt[i] = 0; prv[i] = 0; ord_of[i] = 0; taken[i] = 0; on_list[i] = 0;
            end
            for (int o = 0; o <= TOPO; o++)
                head[o] = NIL;
        endfunction

        function int usable();
            return (count_reg > NPAGES) ? NPAGES : count_reg;
        endfunction

        function logic [31:0] addr_of(int idx);
            logic [31:0] off;
            off = idx * 4096;
            return base_addr + off;
        endfunction

        function void config_write(int idx, logic [31:0] data);
            if (idx == CFG_BASE)
                base_addr = data;
            else
                count_reg = int'(data[12:0]);
        endfunction

        function void push(int o, int idx);
            int h;
            h = head[o];
            nxt[idx] = h;
            prv[idx] = NIL;
            if (h < NIL)
                prv[h] = idx;
            head[o] = idx;
            on_list[idx] = 1;
            ord_of[idx] = o;
            taken[idx] = 0;
        endfunction

        function void unlink(int o, int idx);
            int p, n;
            p = prv[idx];
            n = nxt[idx];
            if (p < NIL)
                nxt[p] = n;
            else
                head[o] = n;
            if (n < NIL)
                prv[n] = p;
            on_list[idx] = 0;
        endfunction

        // Merge with free buddies of equal order, then push the result.
        function void give_back(int idx, int o);
            int np, bud;
            np = usable();
            taken[idx] = 0;
            while (o < TOPO)
            begin
                bud = idx ^ (1 << o);
                if (bud >= np || !on_list[bud] || taken[bud] || ord_of[bud] != o)
                    break;
                unlink(o, bud);
                idx &= ~(1 << o);
                o++;
            end
            push(o, idx);
        endfunction

        // Note an accepted request word and queue its answer.
        function answer_t note(req_t rq, int o, bit sup, int fidx);
            answer_t a;
            int np, cur, idx;
            bit found;
            a.st = ST_IGNORED; a.idx = 0; a.addr = 0;
            np = usable();
            if (rq == REQ_INIT)
            begin
                for (int i = 0; i < NPAGES; i++)
                begin
                    ord_of[i] = 0; taken[i] = 0; on_list[i] = 0;
                end
                for (int k = 0; k <= TOPO; k++)
                    head[k] = NIL;
                for (int i = 0; i + (1 << TOPO) <= np; i += (1 << TOPO))
                    push(TOPO, i);
                a.st = ST_INIT;
            end
            else if (rq == REQ_ALLOC)
            begin
                a.st = ST_FAIL;
                found = 0;
                idx = 0;
                cur = o;
                if (o <= TOPO)
                begin
                    for (cur = o; cur <= TOPO; cur++)
                        if (head[cur] < NIL)
                        begin
                            idx = head[cur];
                            unlink(cur, idx);
                            found = 1;
                            break;
                        end
                    if (found)
                    begin
                        while (cur > o)
                        begin
                            cur--;
                            push(cur, idx + (1 << cur));
                        end
                        taken[idx] = 1;
                        ord_of[idx] = o;
                        if (sup && (o != TOPO || (addr_of(idx) & 32'h003F_FFFF) != 0))
                        begin
                            give_back(idx, o);
                            found = 0;
                        end
                        if (found)
                        begin
                            a.st = ST_DONE;
                            a.idx = 12'(idx);
                            a.addr = addr_of(idx);
                        end
                    end
                end
            end
            else if (rq == REQ_FREE)
            begin
                if (o <= TOPO && fidx < np && fidx + (1 << o) <= np && taken[fidx])
                begin
                    give_back(fidx, o);
                    a.st = ST_DONE;
                end
            end
            pending.push_back(a);
            return a;
        endfunction

        function void check(status_t st, logic [11:0] idx, logic [31:0] addr);
            answer_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word status=%0d page=%0d addr=%h",
                         $time, st, idx, addr);
                return;
            end
            e = pending.pop_front();
            if (st !== e.st)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            end
            if (idx !== e.idx)
            begin
                errors++;
                $display("%0t: page_index expected %0d actual %0d", $time, e.idx, idx);
            end
            if (addr !== e.addr)
            begin
                errors++;
                $display("%0t: phys_address expected %h actual %h", $time, e.addr, addr);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req_type;
    logic [3:0]  block_order;
    logic        want_superpage;
    logic [11:0] free_index;
    logic        done;
    status_t     status;
    logic [11:0] page_index;
    logic [31:0] phys_address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    alloc_scoreboard sb;
    block_t          live_blocks[$];   // blocks the bench believes are allocated
    int              cycles = 0;
    int              n_items;

    buddy_page_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .block_order    (block_order),
        .want_superpage (want_superpage),
        .free_index     (free_index),
        .done           (done),
        .status         (status),
        .page_index     (page_index),
        .phys_address   (phys_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: drop the run if the block stops answering.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The result word lives for one cycle only; take it at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(status, page_index, phys_address);
    end

    // Issue one request word after a random gap; hold start high when the gap
    // is zero so back-to-back words never toggle it within one step.
    task automatic send(req_t rq, int o, int sup, int fidx);
        int gap;
        answer_t a;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        req_type       <= rq;
        block_order    <= o[3:0];
        want_superpage <= sup[0];
        free_index     <= fidx[11:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        a = sb.note(rq, o, sup[0], fidx);
        n_items++;
        if (rq == REQ_INIT)
            live_blocks.delete();
        else if (rq == REQ_ALLOC && a.st == ST_DONE)
            live_blocks.push_back('{int'(a.idx), o});
    endtask

    // Free one tracked block with its own order: the well-formed release path.
    task automatic free_live();
        int k;
        block_t b;
        if (live_blocks.size() == 0)
        begin
            send(REQ_FREE, $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 4095));
            return;
        end
        k = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[k];
        live_blocks.delete(k);
        send(REQ_FREE, b.ord, $urandom_range(0, 1), b.idx);
    endtask

    // Drain outstanding answers, then let the block settle before a register write.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.config_write(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Mostly alloc/free traffic on live blocks with small orders; the rest is noise.
    task automatic random_traffic(int count);
        int pick, o;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 4);
            if (pick < 45)
                send(REQ_ALLOC, o, int'($urandom_range(0, 9) == 0), $urandom_range(0, 4095));
            else if (pick < 85)
                free_live();
            else if (pick < 89)
                send(REQ_ALLOC, $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 4095));
            else if (pick < 96)
                send(REQ_FREE, $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 4095));
            else if (pick < 99)
                send(req_t'(2'd3), $urandom_range(0, 15), $urandom_range(0, 1),
                     $urandom_range(0, 4095));
            else
                send(REQ_INIT, $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 4095));
        end
    endtask

    task automatic phase(logic [31:0] base, int count, int items);
        quiesce();
        write_reg(CFG_BASE, base);
        write_reg(CFG_COUNT, count);
        send(REQ_INIT, 0, 0, 0);
        random_traffic(items);
    endtask

    initial
    begin
        sb             = new();
        n_items        = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_INIT;
        block_order    = '0;
        want_superpage = 1'b0;
        free_index     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = 1'b0;
        cfg_data       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: requests before any init, unknown request, then the edges.
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_FREE, 0, 0, 0);
        send(req_t'(2'd3), 15, 1, 4095);
        send(REQ_INIT, 0, 0, 0);
        send(REQ_ALLOC, 0, 0, 0);
        send(REQ_ALLOC, 10, 1, 0);         // aligned superpage succeeds
        send(REQ_ALLOC, 5, 1, 0);          // superpage below top order is refused
        send(REQ_ALLOC, 11, 0, 0);         // order too large
        send(REQ_ALLOC, 15, 0, 0);
        send(REQ_FREE, 15, 0, 4095);       // order too large
        send(REQ_FREE, 0, 0, 7);           // page not allocated
        send(REQ_FREE, 0, 0, 4095);
        free_live();
        free_live();
        send(REQ_ALLOC, 3, 0, 0);
        free_live();
        send(REQ_ALLOC, 10, 0, 0);
        send(REQ_ALLOC, 10, 0, 0);
        send(REQ_ALLOC, 10, 0, 0);
        send(REQ_ALLOC, 10, 0, 0);
        send(REQ_ALLOC, 0, 0, 0);          // every list empty
        free_live();

        // Wrapping address, count above the page store, misaligned superpage.
        quiesce();
        write_reg(CFG_BASE, 32'hFFFF_F000);
        write_reg(CFG_COUNT, 8191);
        send(REQ_INIT, 0, 0, 0);
        send(REQ_ALLOC, 10, 1, 0);
        send(REQ_ALLOC, 0, 0, 0);

        phase(32'h0040_0000, 4096, 200);
        phase($urandom(), 1500, 180);
        phase(32'hFFFF_FFFF, 0, 30);
        phase(32'($urandom_range(0, 1023)) << 22, 1024, 180);
        phase(32'h0000_0000, 2500, 180);
        phase($urandom(), 4096, 180);

        quiesce();
        $display("Ran %0d request words over eight register settings; %0d answers checked.",
                 n_items, sb.checked);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
